// ===== hw/rtl/itoa_pkg.sv =====
// Shared constants, types and the digit-to-character function for the
// integer-to-ASCII converter. Depends on nothing.
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int ADDR_W      = $clog2(VALUE_WIDTH);
    localparam int PTR_W       = $clog2(VALUE_WIDTH + 1);
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] MAX_DIGIT   = RADIX_W'(35);
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(97);
    localparam logic [CHAR_W-1:0] CHAR_NUL  = CHAR_W'(0);

    // Result of one division pass.
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quot;
        logic [RADIX_W-1:0]     rem;
    } t_div_res;

    // Keeps the low VALUE_WIDTH bits of the input, zero-extending if narrower.
    function automatic logic [VALUE_WIDTH-1:0] fit_value(input logic [IN_W-1:0] x);
        logic [IN_W+VALUE_WIDTH-1:0] ext;
        ext = {{VALUE_WIDTH{1'b0}}, x};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [CHAR_W-1:0] digit_code(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] code;
        if (d > MAX_DIGIT) begin
            code = CHAR_NUL;
        end else if (d < DEC_DIGITS) begin
            code = CHAR_ZERO + CHAR_W'(d);
        end else begin
            code = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/itoa_div.sv =====
// Restoring shift-subtract divider: one quotient bit per cycle.
// Depends on itoa_pkg.
module itoa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [itoa_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  logic [itoa_pkg::RADIX_W-1:0] i_radix,
    output itoa_pkg::t_div_res           o_res
);
    import itoa_pkg::*;

    logic [VALUE_WIDTH-1:0] r_dvd;
    logic [RADIX_W-1:0]     r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [RADIX_W:0]       rem_sh;
    logic [RADIX_W:0]       diff;
    logic                   ge;

    always_comb begin
        rem_sh = {r_rem, r_dvd[VALUE_WIDTH-1]};
        ge     = rem_sh >= {1'b0, i_radix};
        diff   = rem_sh - {1'b0, i_radix};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[VALUE_WIDTH-2:0], ge};
                r_rem <= ge ? diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
                if (r_cnt == CNT_W'(VALUE_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_dvd;
    assign o_res.rem  = r_rem;

endmodule

// ===== hw/rtl/itoa_stack.sv =====
// Digit store: holds remainders least significant first so that they can be
// read back in reverse. Depends on itoa_pkg.
module itoa_stack (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [itoa_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [itoa_pkg::RADIX_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [itoa_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [itoa_pkg::RADIX_W-1:0] o_rd_data
);
    import itoa_pkg::*;

    logic [RADIX_W-1:0] r_mem [VALUE_WIDTH];
    logic [RADIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/int_to_ascii_radix.sv =====
// Top level of the integer-to-ASCII converter: sequencer, radix register and
// output register. Depends on itoa_pkg, itoa_div and itoa_stack.
//
//  Channel  | Direction | Handshake                | Payload
//  ---------+-----------+--------------------------+---------------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_value
//  out      | output    | o_out_valid / i_out_ready| o_digit_char, o_last_digit,
//           |           |                          | o_bad_radix
//  cfg      | input     | i_cfg_wr_en              | i_cfg_wr_data (radix)
//
// Each digit costs one pass of the shared divider; the digits are then read back
// from the digit store in reverse and emitted. A bad radix gives its single result
// from the S_BAD state once the output is free. The input is taken only while the
// sequencer is idle. Reset sets the radix to 10; a stalled output holds the
// sequencer in its emit step.
module int_to_ascii_radix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [itoa_pkg::RADIX_W-1:0] i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [itoa_pkg::IN_W-1:0]    i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last_digit,
    output logic                         o_bad_radix
);
    import itoa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_RD,
        S_LD,
        S_BAD
    } t_state;

    t_state                 r_state, n_state;
    logic [RADIX_W-1:0]     r_radix;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [PTR_W-1:0]       r_ptr, n_ptr;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;
    logic                   r_bad, n_bad;

    t_div_res               div_res;
    logic [RADIX_W-1:0]     rd_data;
    logic [PTR_W-1:0]       ptr_dec;
    logic                   radix_bad;
    logic                   out_free;
    logic                   push;

    assign radix_bad = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
    assign out_free  = !r_out_valid || i_out_ready;
    assign ptr_dec   = r_ptr - PTR_W'(1);
    assign push      = (r_state == S_DIV) && div_res.done;

    itoa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (r_val),
        .i_radix    (r_radix),
        .o_res      (div_res)
    );

    itoa_stack u_stack (
        .i_clk      (i_clk),
        .i_wr_en    (push),
        .i_wr_addr  (r_ptr[ADDR_W-1:0]),
        .i_wr_data  (div_res.rem),
        .i_rd_en    (r_state == S_RD),
        .i_rd_addr  (ptr_dec[ADDR_W-1:0]),
        .o_rd_data  (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_bad       = r_bad;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val = fit_value(i_value);
                    n_ptr = '0;
                    n_state = radix_bad ? S_BAD : S_START;
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_ptr = r_ptr + PTR_W'(1);
                    n_val = div_res.quot;
                    n_state = (div_res.quot == '0) ? S_RD : S_START;
                end
            end
            S_RD: begin
                n_ptr   = ptr_dec;
                n_state = S_LD;
            end
            S_LD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_code(rd_data);
                    n_last      = (r_ptr == '0);
                    n_bad       = 1'b0;
                    n_state     = (r_ptr == '0) ? S_IDLE : S_RD;
                end
            end
            S_BAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_NUL;
                    n_last      = 1'b1;
                    n_bad       = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_radix <= i_cfg_wr_data;
            end
        end
        r_val  <= n_val;
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;
    assign o_bad_radix  = r_bad;

endmodule
